/* hw/rtl/gpio_pin_interrupt_unit_defines.svh */
// ----------------------------------------------------------------------------
// GPIO pin interrupt unit - assertion macros
// Shared concurrent assertion forms, clocked on clock and idle in reset.
// ----------------------------------------------------------------------------
`ifndef GPIO_PIN_INTERRUPT_UNIT_DEFINES_SVH
`define GPIO_PIN_INTERRUPT_UNIT_DEFINES_SVH

// condition must hold at every edge outside reset
`define GPIU_ASSERT_NOW(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define GPIU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/gpiu_pkg.sv */
// ----------------------------------------------------------------------------
// GPIO pin interrupt unit - package
// Types, operation codes and constants shared by the lanes and merge stage.
// ----------------------------------------------------------------------------
package gpiu_pkg;

   // pin geometry
   localparam int unsigned PIN_MAX       = 64;
   localparam int unsigned PIN_COUNT_DEF = 64;
   localparam int unsigned IDX_W         = 6;
   localparam int unsigned MODE_W        = 5;

   // interrupt mode bits
   localparam int unsigned MODE_RISE = 0;
   localparam int unsigned MODE_FALL = 1;
   localparam int unsigned MODE_BOTH = 2;
   localparam int unsigned MODE_HIGH = 3;
   localparam int unsigned MODE_LOW  = 4;

   // level timer
   localparam int unsigned PERIOD_W       = 16;
   localparam logic [15:0] PERIOD_DEFAULT = 16'd1000;

   // register file
   localparam int unsigned CSR_ADDR_W           = 3;
   localparam int unsigned CSR_DATA_W           = 32;
   localparam logic        CSR_IDX_LEVEL_PERIOD = 1'b0;

   typedef enum logic [2:0] {
      OP_WRITE_ALL = 3'd0,
      OP_WRITE_PIN = 3'd1,
      OP_READ_PIN  = 3'd2,
      OP_ATTACH    = 3'd3,
      OP_DETACH    = 3'd4,
      OP_TICK      = 3'd5
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    pin_index;
      logic                pin_value;
      logic [PIN_MAX-1:0]  all_pins;
      logic [MODE_W-1:0]   irq_mode;
   } req_type;

   typedef struct packed {
      logic                read_level;
      logic [PIN_MAX-1:0]  pin_levels;
      logic [PIN_MAX-1:0]  edge_fire;
      logic [PIN_MAX-1:0]  level_fire;
   } rsp_type;

   // what one lane reports for the current transfer
   typedef struct packed {
      logic edge_hit;
      logic level_cur;
      logic level_next;
      logic efire;
      logic lvl_cand;
      logic lvl_mode_next;
   } lane_stat_type;

   // the same, gathered over all pins
   typedef struct packed {
      logic [PIN_MAX-1:0] edge_hit;
      logic [PIN_MAX-1:0] level_cur;
      logic [PIN_MAX-1:0] level_next;
      logic [PIN_MAX-1:0] efire;
      logic [PIN_MAX-1:0] lvl_cand;
      logic [PIN_MAX-1:0] lvl_mode_next;
   } lane_vec_type;

endpackage

/* hw/rtl/gpiu_pin_lane.sv */
// ----------------------------------------------------------------------------
// GPIO pin interrupt unit - pin lane
// Level, mode, handler and trigger state of one pin and its per-pin update.
// ----------------------------------------------------------------------------
module gpiu_pin_lane #(
   parameter int unsigned LANE = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  gpiu_pkg::req_type      req,
   input  logic                   edge_any,
   output gpiu_pkg::lane_stat_type stat
);
   import gpiu_pkg::*;

   logic              level_ff, level_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              handler_ff, handler_in;
   logic              trig_ff, trig_in;

   logic sel, now, rise, fall, ep, en, hi, lo, edge_mode, t1, efire, is_wall;

   assign sel     = (req.pin_index == IDX_W'(LANE));
   assign now     = req.all_pins[LANE];
   assign is_wall = (req.op == OP_WRITE_ALL);

   // whole-port write: edge detect and level trigger update
   always_comb begin
      rise      = ~level_ff & now;
      fall      = level_ff & ~now;
      ep        = handler_ff & (mode_ff[MODE_RISE] | mode_ff[MODE_BOTH]) & rise;
      en        = handler_ff & (mode_ff[MODE_FALL] | mode_ff[MODE_BOTH]) & fall;
      hi        = handler_ff & mode_ff[MODE_HIGH];
      lo        = handler_ff & mode_ff[MODE_LOW];
      edge_mode = mode_ff[MODE_RISE] | mode_ff[MODE_FALL] | mode_ff[MODE_BOTH];
      t1        = (trig_ff | ep | en | (hi & now) | (lo & ~now))
                  & ~((lo & now) | (hi & ~now));
      efire     = is_wall & edge_any & t1 & handler_ff & edge_mode;
   end

   // next state per operation
   always_comb begin
      level_in   = level_ff;
      mode_in    = mode_ff;
      handler_in = handler_ff;
      trig_in    = trig_ff;
      unique case (req.op)
         OP_WRITE_ALL: begin
            level_in = now;
            trig_in  = t1 & ~efire;
         end
         OP_WRITE_PIN: begin
            if (sel) level_in = req.pin_value;
         end
         OP_ATTACH: begin
            if (sel) begin
               handler_in = 1'b1;
               mode_in    = req.irq_mode;
               if ((req.irq_mode[MODE_HIGH] & level_ff) |
                   (req.irq_mode[MODE_LOW] & ~level_ff)) trig_in = 1'b1;
            end
         end
         OP_DETACH: begin
            if (sel) begin
               handler_in = 1'b0;
               mode_in    = '0;
               trig_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 1'b0;
         mode_ff    <= '0;
         handler_ff <= 1'b0;
         trig_ff    <= 1'b0;
      end else if (accept) begin
         level_ff   <= level_in;
         mode_ff    <= mode_in;
         handler_ff <= handler_in;
         trig_ff    <= trig_in;
      end
   end

   // status towards the merge stage
   always_comb begin
      stat.edge_hit      = is_wall & (ep | en);
      stat.level_cur     = level_ff;
      stat.level_next    = level_in;
      stat.efire         = efire;
      stat.lvl_cand      = trig_ff & handler_ff & (mode_ff[MODE_HIGH] | mode_ff[MODE_LOW]);
      stat.lvl_mode_next = mode_in[MODE_HIGH] | mode_in[MODE_LOW];
   end

endmodule

/* hw/rtl/gpiu_merge.sv */
// ----------------------------------------------------------------------------
// GPIO pin interrupt unit - merge stage
// Reduces lane status, runs the level timer and period register, and holds
// the result register with its handshake.
// ----------------------------------------------------------------------------
`include "gpio_pin_interrupt_unit_defines.svh"

module gpiu_merge #(
   parameter int unsigned PIN_COUNT = gpiu_pkg::PIN_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gpiu_pkg::req_type             req,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gpiu_pkg::rsp_type             rsp,
   input  gpiu_pkg::lane_vec_type        lanes,
   output logic                          accept,
   output logic                          edge_any,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gpiu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gpiu_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gpiu_pkg::CSR_DATA_W-1:0] csr_prdata
);
   import gpiu_pkg::*;

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] tick_ff, tick_in, tick_inc;
   logic                running_ff, running_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                pin_ok, lvl_fire, csr_wr;

   // handshake: result register frees itself when taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign pin_ok   = ({1'b0, req.pin_index} < (IDX_W + 1)'(PIN_COUNT));
   assign edge_any = |lanes.edge_hit;
   assign tick_inc = tick_ff + 16'd1;

   // period register, zero writes ignored
   assign csr_wr = csr_psel & csr_penable & csr_pwrite
                   & (csr_paddr[2] == CSR_IDX_LEVEL_PERIOD);
   always_comb begin
      period_in = period_ff;
      if (csr_wr && csr_pwdata[PERIOD_W-1:0] != '0) period_in = csr_pwdata[PERIOD_W-1:0];
   end
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_LEVEL_PERIOD)
                       ? {{(CSR_DATA_W - PERIOD_W){1'b0}}, period_ff} : '0;

   // level timer
   always_comb begin
      running_in = running_ff;
      tick_in    = tick_ff;
      lvl_fire   = 1'b0;
      unique case (req.op)
         OP_ATTACH: begin
            if (pin_ok && (req.irq_mode[MODE_HIGH] || req.irq_mode[MODE_LOW])
                && !running_ff) begin
               running_in = 1'b1;
               tick_in    = '0;
            end
         end
         OP_DETACH: begin
            if (pin_ok && !(|lanes.lvl_mode_next)) running_in = 1'b0;
         end
         OP_TICK: begin
            if (running_ff) begin
               if (tick_inc >= period_ff) begin
                  tick_in  = '0;
                  lvl_fire = 1'b1;
               end else begin
                  tick_in = tick_inc;
               end
            end
         end
         default: ;
      endcase
   end

   // result assembly
   always_comb begin
      rsp_in.read_level = (req.op == OP_READ_PIN) & pin_ok & lanes.level_cur[req.pin_index];
      rsp_in.pin_levels = lanes.level_next;
      rsp_in.edge_fire  = lanes.efire;
      rsp_in.level_fire = lvl_fire ? lanes.lvl_cand : '0;
      rsp_valid_in      = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_DEFAULT;
         tick_ff      <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            tick_ff    <= tick_in;
            running_ff <= running_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   // checks
   `GPIU_ASSERT_NEXT(a_edge, accept && req.op != OP_WRITE_ALL, ~|rsp_ff.edge_fire, "edge fire")
   `GPIU_ASSERT_NEXT(a_lvl_timer, accept && !running_ff, ~|rsp_ff.level_fire, "timer stopped")
   `GPIU_ASSERT_NOW(a_period_nonzero, period_ff != '0, "level period is zero")

endmodule

/* hw/rtl/gpio_pin_interrupt_unit.sv */
// ----------------------------------------------------------------------------
// GPIO pin interrupt unit - top level
// GPIO port with per-pin edge and level interrupts, one lane per pin.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  req_data  (req_type)
//  rsp_      out        rsp_valid/rsp_stall  rsp_data  (rsp_type)
//  csr_      in/out     APB psel/penable     level_period at byte 0
//
//  One transfer per cycle while req_stall is low; each result appears in the cycle
//  after acceptance, from the single register stage after the pin lanes and merge reduction.
//  Synchronous reset clears all pin state, the timer and sets period to 1000.
//  req_stall rises only while a result is held and rsp_stall is high.
// ----------------------------------------------------------------------------
module gpio_pin_interrupt_unit #(
   parameter int unsigned PIN_COUNT = gpiu_pkg::PIN_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gpiu_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gpiu_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gpiu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gpiu_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gpiu_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import gpiu_pkg::*;

   lane_stat_type lane_stat [PIN_MAX];
   lane_vec_type  lanes;
   logic          accept;
   logic          edge_any;

   assign csr_pready = 1'b1;

   // one lane per implemented pin, absent pins read as zero
   for (genvar i = 0; i < PIN_MAX; i++) begin : g_lane
      if (i < PIN_COUNT) begin : g_on
         gpiu_pin_lane #(
            .LANE (i)
         ) u_lane (
            .clock    (clock),
            .reset    (reset),
            .accept   (accept),
            .req      (req_data),
            .edge_any (edge_any),
            .stat     (lane_stat[i])
         );
      end else begin : g_off
         assign lane_stat[i] = '0;
      end
   end

   // gather lane status into pin vectors
   always_comb begin
      for (int i = 0; i < PIN_MAX; i++) begin
         lanes.edge_hit[i]      = lane_stat[i].edge_hit;
         lanes.level_cur[i]     = lane_stat[i].level_cur;
         lanes.level_next[i]    = lane_stat[i].level_next;
         lanes.efire[i]         = lane_stat[i].efire;
         lanes.lvl_cand[i]      = lane_stat[i].lvl_cand;
         lanes.lvl_mode_next[i] = lane_stat[i].lvl_mode_next;
      end
   end

   gpiu_merge #(
      .PIN_COUNT (PIN_COUNT)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp_data),
      .lanes       (lanes),
      .accept      (accept),
      .edge_any    (edge_any),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule
